>>> sv/fwpd_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and register codes for the four wheel pid drive
package fwpd_pkg;

  localparam int WHEELS         = 4;
  localparam int SUM_WIDTH      = 24;
  localparam int GAIN_FRAC_BITS = 6;

  localparam int IN_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int MAG_W   = 15;
  localparam int MASK_W  = WHEELS;
  localparam int ERR_W   = IN_W + 1;
  localparam int DELTA_W = ERR_W + 1;
  localparam int PP_W    = GAIN_W + 1 + ERR_W;
  localparam int PI_W    = GAIN_W + 1 + SUM_WIDTH;
  localparam int PD_W    = GAIN_W + 1 + DELTA_W;
  localparam int ACC_W   = PI_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_P_RESET      = 16'd12800;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET      = 16'd1280;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET      = 16'd320;
  localparam logic [MAG_W-1:0]  DRIVE_LIMIT_RESET = 15'd8000;
  localparam logic [MASK_W-1:0] INVERT_MASK_RESET = 4'd10;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    (ACC_W'(1) <<< GAIN_FRAC_BITS) - ACC_W'(1);

  typedef struct packed {
    logic                   enable;
    logic signed [IN_W-1:0] count_a;
    logic signed [IN_W-1:0] count_b;
    logic signed [IN_W-1:0] count_c;
    logic signed [IN_W-1:0] count_d;
    logic signed [IN_W-1:0] target_a;
    logic signed [IN_W-1:0] target_b;
    logic signed [IN_W-1:0] target_c;
    logic signed [IN_W-1:0] target_d;
  } tick_word_t;

  typedef struct packed {
    logic             dir_a;
    logic [MAG_W-1:0] mag_a;
    logic             dir_b;
    logic [MAG_W-1:0] mag_b;
    logic             dir_c;
    logic [MAG_W-1:0] mag_c;
    logic             dir_d;
    logic [MAG_W-1:0] mag_d;
  } drive_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [MAG_W-1:0]  drive_limit;
    logic [MASK_W-1:0] invert_mask;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic adv;
  } lane_ctl_t;

endpackage

>>> sv/fwpd_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick, drive and config words
interface fwpd_tick_if import fwpd_pkg::*; ();
  logic       valid;
  logic       ready;
  tick_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fwpd_drive_if import fwpd_pkg::*; ();
  logic        valid;
  logic        ready;
  drive_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fwpd_cfg_if import fwpd_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/fwpd_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file: gains, drive limit and invert mask
module fwpd_cfg_regs import fwpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  input  cfg_word_t wr_word,
  output logic      wr_ready,
  output cfg_t      cfg
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= GAIN_P_RESET;
      cfg.gain_i      <= GAIN_I_RESET;
      cfg.gain_d      <= GAIN_D_RESET;
      cfg.drive_limit <= DRIVE_LIMIT_RESET;
      cfg.invert_mask <= INVERT_MASK_RESET;
    end else if (wr_valid) begin
      unique case (wr_word.index)
        REG_GAIN_P:      cfg.gain_p      <= wr_word.data[GAIN_W-1:0];
        REG_GAIN_I:      cfg.gain_i      <= wr_word.data[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d      <= wr_word.data[GAIN_W-1:0];
        REG_DRIVE_LIMIT: cfg.drive_limit <= wr_word.data[MAG_W-1:0];
        REG_INVERT_MASK: cfg.invert_mask <= wr_word.data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/fwpd_lane.sv
`timescale 1ns / 1ps
// one wheel lane: error and integral update, gain products, scale and clamp
module fwpd_lane import fwpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctl_t              ctl,
  input  logic                   enable,
  input  logic                   invert,
  input  logic signed [IN_W-1:0] count,
  input  logic signed [IN_W-1:0] target,
  input  cfg_t                   cfg,
  output logic                   dir,
  output logic [MAG_W-1:0]       mag
);

  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [ERR_W-1:0]     previous_error;

  logic signed [ERR_W-1:0]     cnt_ext;
  logic signed [ERR_W-1:0]     cnt_sgn;
  logic signed [ERR_W-1:0]     err;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic signed [DELTA_W-1:0]   delta;

  logic                        en1;
  logic signed [ERR_W-1:0]     err1;
  logic signed [SUM_WIDTH-1:0] sum1;
  logic signed [DELTA_W-1:0]   delta1;

  logic                        en2;
  logic signed [PP_W-1:0]      prod_p;
  logic signed [PI_W-1:0]      prod_i;
  logic signed [PD_W-1:0]      prod_d;

  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     quot;
  logic signed [ACC_W-1:0]     abs_q;
  logic signed [ACC_W-1:0]     lim_ext;

  always_comb begin
    cnt_ext  = ERR_W'(count);
    cnt_sgn  = invert ? -cnt_ext : cnt_ext;
    err      = ERR_W'(target) - cnt_sgn;
    sum_wide = (SUM_WIDTH+1)'(error_sum) + (SUM_WIDTH+1)'(err);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
    delta = DELTA_W'(err) - DELTA_W'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (ctl.load && enable) begin
      error_sum      <= sum_next;
      previous_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      en1    <= enable;
      err1   <= err;
      sum1   <= sum_next;
      delta1 <= delta;
      en2    <= en1;
      prod_p <= PP_W'(signed'({1'b0, cfg.gain_p})) * PP_W'(err1);
      prod_i <= PI_W'(signed'({1'b0, cfg.gain_i})) * PI_W'(sum1);
      prod_d <= PD_W'(signed'({1'b0, cfg.gain_d})) * PD_W'(delta1);
    end
  end

  // truncate toward zero, then clamp to the drive limit
  always_comb begin
    acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    if (acc[ACC_W-1]) begin
      acc = acc + ROUND_BIAS;
    end
    quot    = acc >>> GAIN_FRAC_BITS;
    abs_q   = quot[ACC_W-1] ? -quot : quot;
    lim_ext = ACC_W'(cfg.drive_limit);
    if (!en2) begin
      dir = 1'b1;
      mag = '0;
    end else begin
      dir = !(quot[ACC_W-1] && (cfg.drive_limit != '0));
      mag = (abs_q > lim_ext) ? cfg.drive_limit : abs_q[MAG_W-1:0];
    end
  end

endmodule

>>> sv/fwpd_merge.sv
`timescale 1ns / 1ps
// pipeline control and output register that gathers the lane results
module fwpd_merge import fwpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output lane_ctl_t        ctl,
  input  logic             lane_dir [WHEELS],
  input  logic [MAG_W-1:0] lane_mag [WHEELS],
  output logic             out_valid,
  input  logic             out_ready,
  output drive_word_t      out_word
);

  logic v1;
  logic v2;
  logic adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign ctl.adv  = adv;
  assign ctl.load = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      out_word.dir_a <= lane_dir[0];
      out_word.mag_a <= lane_mag[0];
      out_word.dir_b <= lane_dir[1];
      out_word.mag_b <= lane_mag[1];
      out_word.dir_c <= lane_dir[2];
      out_word.mag_c <= lane_mag[2];
      out_word.dir_d <= lane_dir[3];
      out_word.mag_d <= lane_mag[3];
    end
  end

endmodule

>>> sv/four_wheel_pid_drive.sv
`timescale 1ns / 1ps
// Four wheel positional PID drive. Each tick word carries an enable flag,
// four encoder counts and four target speeds; each drive word gives a
// direction bit and a clamped magnitude per wheel. A new tick word is taken
// every clock cycle while no drive word is held back, and its drive word
// passes these registers in order: error and integral update into the
// first register at the accepting edge, then the three gain products, then
// scaling, clamping and the output register. A drive word that waits stalls
// the whole pipeline and the tick side with it. Four lanes run side by side
// and hold the integral and previous error of their wheel. Config words are
// taken at any time but are meant to be written while no tick is in flight.
module four_wheel_pid_drive import fwpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  fwpd_tick_if.sink    tick,
  fwpd_drive_if.source drive,
  fwpd_cfg_if.sink     cfg
);

  cfg_t                   regs;
  lane_ctl_t              ctl;
  logic signed [IN_W-1:0] count  [WHEELS];
  logic signed [IN_W-1:0] target [WHEELS];
  logic                   lane_dir [WHEELS];
  logic [MAG_W-1:0]       lane_mag [WHEELS];

  assign count[0]  = tick.payload.count_a;
  assign count[1]  = tick.payload.count_b;
  assign count[2]  = tick.payload.count_c;
  assign count[3]  = tick.payload.count_d;
  assign target[0] = tick.payload.target_a;
  assign target[1] = tick.payload.target_b;
  assign target[2] = tick.payload.target_c;
  assign target[3] = tick.payload.target_d;

  fwpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_word  (cfg.payload),
    .wr_ready (cfg.ready),
    .cfg      (regs)
  );

  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    fwpd_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .enable (tick.payload.enable),
      .invert (regs.invert_mask[w]),
      .count  (count[w]),
      .target (target[w]),
      .cfg    (regs),
      .dir    (lane_dir[w]),
      .mag    (lane_mag[w])
    );
  end

  fwpd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .ctl       (ctl),
    .lane_dir  (lane_dir),
    .lane_mag  (lane_mag),
    .out_valid (drive.valid),
    .out_ready (drive.ready),
    .out_word  (drive.payload)
  );

endmodule
